FILE: hw/rtl/tksd_pkg.sv
// ----------------------------------------------------------------------------
// tksd_pkg
// Shared types and constants for the terminal key sequence decoder.
// ----------------------------------------------------------------------------
package tksd_pkg;

    localparam int ParamDepth = 64;
    localparam int PtrW       = $clog2(ParamDepth);
    localparam int CntW       = $clog2(ParamDepth + 1);
    localparam logic [21:0] NumMax = 22'd2097151;

    localparam logic [3:0] KEY_ESC   = 4'd0;
    localparam logic [3:0] KEY_ENTER = 4'd1;
    localparam logic [3:0] KEY_BKSP  = 4'd2;
    localparam logic [3:0] KEY_SPACE = 4'd3;
    localparam logic [3:0] KEY_LEFT  = 4'd4;
    localparam logic [3:0] KEY_RIGHT = 4'd5;
    localparam logic [3:0] KEY_UP    = 4'd6;
    localparam logic [3:0] KEY_DOWN  = 4'd7;
    localparam logic [3:0] KEY_CHAR  = 4'd8;
    localparam logic [3:0] KEY_CTRLC = 4'd9;

    localparam logic OP_BYTE  = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    localparam logic [0:0] REG_CTRL_MASK = 1'b0;

    typedef struct packed {
        logic       opcode;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [3:0] key_code;
        logic [7:0] char_value;
        logic [1:0] event_kind;
        logic [7:0] modifier_bits;
        logic       last_of_run;
    } t_out_item;

    // Request to / answer from the parameter scanner.
    typedef struct packed {
        logic           start;
        logic           is_u;
        logic [CntW-1:0] count;
    } t_scan_req;

    typedef struct packed {
        logic        done;
        logic        private_mark;
        logic [21:0] code;
        logic [21:0] mraw;
        logic [21:0] traw;
    } t_scan_rsp;

    function automatic logic is_blank(input logic [7:0] b);
        return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0d);
    endfunction

    function automatic logic [1:0] kind_of(input logic [21:0] raw);
        return (raw == 22'd2) ? 2'd1 : ((raw == 22'd3) ? 2'd2 : 2'd0);
    endfunction

    function automatic logic [7:0] mods_of(input logic [21:0] raw);
        logic [21:0] m;
        m = raw - 22'd1;
        if (raw <= 22'd1) return 8'd0;
        return (m > 22'd255) ? 8'd255 : m[7:0];
    endfunction

endpackage

FILE: hw/rtl/tksd_ram.sv
// ----------------------------------------------------------------------------
// tksd_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tksd_ram #(
    parameter int Width = 8,
    parameter int Depth = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: hw/rtl/tksd_scan.sv
// ----------------------------------------------------------------------------
// tksd_scan
// Walks the stored parameter bytes once, one byte at a time through a read state
// and a run state, and runs a number-parser state machine per subfield to recover code, mods and type.
// ----------------------------------------------------------------------------
module tksd_scan (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tksd_pkg::t_scan_req           i_req,
    input  logic [7:0]                    i_rdata,
    output logic [tksd_pkg::PtrW-1:0]     o_raddr,
    output tksd_pkg::t_scan_rsp           o_rsp
);
    // Number parser phases.
    typedef enum logic [4:0] {
        P_BLANK = 5'b00001,
        P_DIGIT = 5'b00010,
        P_BAD   = 5'b00100,
        P_NUL   = 5'b01000,
        P_SKIP  = 5'b10000
    } t_pphase;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_RUN  = 3'b100
    } t_state;

    t_state  r_state, n_state;
    t_pphase r_ph, n_ph;
    logic [tksd_pkg::CntW-1:0] r_idx, n_idx, r_cnt;
    logic        r_is_u;
    logic [1:0]  r_field, n_field;   // semicolon-delimited field number
    logic        r_sub, n_sub;       // 0 first subfield, 1 second
    logic        r_colon, n_colon;   // a colon already passed in this field
    logic        r_neg, n_neg;
    logic        r_nd, n_nd;
    logic [21:0] r_val, n_val;
    logic [21:0] r_code, n_code, r_mraw, n_mraw, r_traw, n_traw;
    logic        r_priv, n_priv;
    logic        r_done;

    logic [25:0] acc;
    logic [21:0] num;
    logic        num_ok;
    logic        at_end;
    logic [7:0]  b;

    assign o_raddr = r_idx[tksd_pkg::PtrW-1:0];
    assign b = i_rdata;
    assign at_end = (r_idx == r_cnt);
    assign acc = {r_val, 3'b000} + {3'b000, r_val, 1'b0} + {18'd0, b - 8'h30};
    assign num_ok = r_nd && (r_ph == P_DIGIT || r_ph == P_NUL);
    assign num = r_neg ? 22'd0 : r_val;

    assign o_rsp.done = r_done;
    assign o_rsp.private_mark = r_priv;
    assign o_rsp.code = r_code;
    assign o_rsp.mraw = r_mraw;
    assign o_rsp.traw = r_traw;

    always_comb begin
        logic term_field, term_sub, commit;
        n_state = r_state; n_ph = r_ph; n_idx = r_idx; n_field = r_field;
        n_sub = r_sub; n_colon = r_colon; n_neg = r_neg; n_nd = r_nd;
        n_val = r_val; n_code = r_code; n_mraw = r_mraw; n_traw = r_traw;
        n_priv = r_priv;
        term_field = 1'b0; term_sub = 1'b0; commit = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_req.start) begin
                    n_state = S_READ; n_idx = '0; n_field = 2'd0; n_sub = 1'b0;
                    n_colon = 1'b0; n_ph = P_BLANK; n_neg = 1'b0; n_nd = 1'b0;
                    n_val = '0; n_code = 22'd0; n_mraw = 22'd1; n_traw = 22'd1;
                    n_priv = 1'b0;
                end
            end
            S_READ: n_state = S_RUN;   // wait for registered read data
            S_RUN: begin
                term_field = at_end || (b == 8'h3b);
                term_sub = !at_end && (b == 8'h3a);
                if (!at_end && r_idx == '0 && b == 8'h3f) begin
                    n_priv = 1'b1;
                end
                if (term_field || term_sub) begin
                    commit = (r_sub == 1'b0 && !r_colon) || (r_sub == 1'b1 && term_sub == 1'b0)
                             || (r_sub == 1'b1);
                    // first subfield ends at first colon or field end;
                    // second ends at next colon or field end
                    if (!r_colon || r_sub) begin
                        if (r_is_u) begin
                            if (r_field == 2'd0 && !r_sub) begin
                                n_code = num_ok ? num : 22'd0;
                            end else if (r_field == 2'd1 && !r_sub) begin
                                n_mraw = num_ok ? num : 22'd1;
                            end else if (r_field == 2'd1 && r_sub) begin
                                n_traw = num_ok ? num : 22'd1;
                            end
                        end else if (term_field) begin
                            // arrows: only the last field counts; reset on ';'
                            if (!r_sub) begin
                                n_mraw = num_ok ? num : 22'd1;
                                n_traw = 22'd1;
                            end else begin
                                n_traw = num_ok ? num : 22'd1;
                            end
                        end else begin
                            if (!r_sub) begin
                                n_mraw = num_ok ? num : 22'd1;
                                n_traw = 22'd1;
                            end else begin
                                n_traw = num_ok ? num : 22'd1;
                            end
                        end
                    end
                    n_ph = P_BLANK; n_neg = 1'b0; n_nd = 1'b0; n_val = '0;
                    if (term_field) begin
                        if (r_field != 2'd3) n_field = r_field + 2'd1;
                        n_sub = 1'b0; n_colon = 1'b0;
                        if (!r_is_u && !at_end) begin
                            n_mraw = 22'd1; n_traw = 22'd1;
                        end
                    end else begin
                        if (!r_colon) n_sub = 1'b1;
                        else n_ph = P_SKIP;
                        n_colon = 1'b1;
                        if (r_colon) n_sub = 1'b0;
                    end
                end else begin
                    priority case (r_ph)
                        P_BLANK: begin
                            if (b == 8'h00) n_ph = P_NUL;
                            else if (tksd_pkg::is_blank(b)) n_ph = P_BLANK;
                            else if (b == 8'h2b || b == 8'h2d) begin
                                n_neg = (b == 8'h2d); n_ph = P_DIGIT;
                            end else if (b >= 8'h30 && b <= 8'h39) begin
                                n_val = {18'd0, b[3:0]}; n_nd = 1'b1; n_ph = P_DIGIT;
                            end else n_ph = P_BAD;
                        end
                        P_DIGIT: begin
                            if (b == 8'h00) n_ph = P_NUL;
                            else if (b >= 8'h30 && b <= 8'h39) begin
                                n_val = (acc > {4'd0, tksd_pkg::NumMax}) ?
                                        tksd_pkg::NumMax : acc[21:0];
                                n_nd = 1'b1;
                            end else n_ph = P_BAD;
                        end
                        default: ;
                    endcase
                end
                if (commit) n_ph = n_ph;
                if (at_end) n_state = S_IDLE;
                else begin
                    n_idx = r_idx + 1'b1;
                    n_state = S_READ;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == S_RUN) && at_end;
        end
        if (i_req.start && r_state == S_IDLE) begin
            r_cnt  <= i_req.count;
            r_is_u <= i_req.is_u;
        end
        r_ph <= n_ph; r_idx <= n_idx; r_field <= n_field; r_sub <= n_sub;
        r_colon <= n_colon; r_neg <= n_neg; r_nd <= n_nd; r_val <= n_val;
        r_code <= n_code; r_mraw <= n_mraw; r_traw <= n_traw; r_priv <= n_priv;
    end
endmodule

FILE: hw/rtl/terminal_key_sequence_decoder_unit.sv
// ----------------------------------------------------------------------------
// terminal_key_sequence_decoder_unit
// Turns terminal input bytes into key events; decodes CSI keyboard sequences.
// ----------------------------------------------------------------------------
// Plain bytes and ESC handling register up to two key events, which are then
// presented in turn on the output and held there while it is stalled. A CSI
// final byte starts a scan of the stored parameter bytes through a single
// registered RAM read port, with a read state and a run state per byte; a
// finish state then decodes the key event it emits. The input is not ready
// while a transaction is in progress or a result is waiting.
module terminal_key_sequence_decoder_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  tksd_pkg::t_in_item   i_item,
    output logic                 o_valid,
    input  logic                 i_ready,
    output tksd_pkg::t_out_item  o_item,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_OUT1 = 5'b00010,
        ST_OUT2 = 5'b00100,
        ST_SCAN = 5'b01000,
        ST_FIN  = 5'b10000
    } t_state;

    typedef enum logic [1:0] {
        M_NORMAL = 2'd0,
        M_ESC    = 2'd1,
        M_CSI    = 2'd2
    } t_mode;

    t_state r_state;
    t_mode  r_mode;
    logic [7:0] r_mask;
    logic [tksd_pkg::CntW-1:0] r_cnt;
    tksd_pkg::t_out_item r_res1, r_res2;
    logic r_has2;
    logic [7:0] r_fin;
    logic r_start;

    tksd_pkg::t_scan_req req;
    tksd_pkg::t_scan_rsp rsp;
    logic [tksd_pkg::PtrW-1:0] raddr;
    logic [7:0] rdata;
    logic we;

    logic acc_in;
    logic [7:0] b;
    logic pl_ok;
    tksd_pkg::t_out_item pl;
    tksd_pkg::t_out_item esc_item;
    logic esc_last;

    assign pready = 1'b1;
    assign prdata = {24'd0, r_mask};
    assign o_ready = (r_state == ST_IDLE);
    assign acc_in = i_valid && o_ready;
    assign b = i_item.data_byte;
    // Esc closes the run unless a plain key follows it
    assign esc_last = (i_item.opcode == tksd_pkg::OP_FLUSH) || !pl_ok;
    assign esc_item = '{key_code: tksd_pkg::KEY_ESC, char_value: 8'd0, event_kind: 2'd0,
                        modifier_bits: 8'd0, last_of_run: esc_last};
    assign we = acc_in && i_item.opcode == tksd_pkg::OP_BYTE && r_mode == M_CSI
                && !(b >= 8'h40 && b <= 8'h7e) && r_cnt < tksd_pkg::CntW'(tksd_pkg::ParamDepth);

    assign req.start = r_start;
    assign req.is_u  = (r_fin == 8'h75);
    assign req.count = r_cnt;

    // Plain byte decode.
    always_comb begin
        pl = '{key_code: tksd_pkg::KEY_CHAR, char_value: 8'd0, event_kind: 2'd0,
               modifier_bits: 8'd0, last_of_run: 1'b1};
        pl_ok = 1'b1;
        if (b == 8'h03) begin
            pl.key_code = tksd_pkg::KEY_CTRLC; pl.modifier_bits = r_mask;
        end else if (b == 8'h0d || b == 8'h0a) pl.key_code = tksd_pkg::KEY_ENTER;
        else if (b == 8'h7f || b == 8'h08) pl.key_code = tksd_pkg::KEY_BKSP;
        else if (b == 8'h20) pl.key_code = tksd_pkg::KEY_SPACE;
        else if (b > 8'h20 && b < 8'h7f) pl.char_value = b;
        else pl_ok = 1'b0;
    end

    // Final decode from scan results.
    tksd_pkg::t_out_item fi;
    logic fi_ok;
    always_comb begin
        logic [7:0] m;
        logic [21:0] c;
        m = tksd_pkg::mods_of(rsp.mraw);
        c = rsp.code;
        fi = '{key_code: tksd_pkg::KEY_ESC, char_value: 8'd0,
               event_kind: tksd_pkg::kind_of(rsp.traw), modifier_bits: m, last_of_run: 1'b1};
        fi_ok = 1'b1;
        if (rsp.private_mark && r_cnt != '0) fi_ok = 1'b0;
        else if (r_fin == 8'h75) begin
            if ((m & r_mask) != 8'd0 && (c == 22'd99 || c == 22'd67)) fi.key_code = tksd_pkg::KEY_CTRLC;
            else if (c == 22'd27 || c == 22'd57344) fi.key_code = tksd_pkg::KEY_ESC;
            else if (c == 22'd13 || c == 22'd57345 || c == 22'd57414) fi.key_code = tksd_pkg::KEY_ENTER;
            else if (c == 22'd127 || c == 22'd8 || c == 22'd57347) fi.key_code = tksd_pkg::KEY_BKSP;
            else if (c == 22'd32) fi.key_code = tksd_pkg::KEY_SPACE;
            else if (c == 22'd57350 || c == 22'd57417) fi.key_code = tksd_pkg::KEY_LEFT;
            else if (c == 22'd57351 || c == 22'd57418) fi.key_code = tksd_pkg::KEY_RIGHT;
            else if (c == 22'd57352 || c == 22'd57419) fi.key_code = tksd_pkg::KEY_UP;
            else if (c == 22'd57353 || c == 22'd57420) fi.key_code = tksd_pkg::KEY_DOWN;
            else if (c > 22'd32 && c < 22'd127) begin
                fi.key_code = tksd_pkg::KEY_CHAR; fi.char_value = c[7:0];
            end else fi_ok = 1'b0;
        end else if (r_fin == 8'h41) fi.key_code = tksd_pkg::KEY_UP;
        else if (r_fin == 8'h42) fi.key_code = tksd_pkg::KEY_DOWN;
        else if (r_fin == 8'h43) fi.key_code = tksd_pkg::KEY_RIGHT;
        else if (r_fin == 8'h44) fi.key_code = tksd_pkg::KEY_LEFT;
        else fi_ok = 1'b0;
    end

    assign o_valid = (r_state == ST_OUT1) || (r_state == ST_OUT2);
    assign o_item  = (r_state == ST_OUT2) ? r_res2 : r_res1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_mode  <= M_NORMAL;
            r_cnt   <= '0;
            r_mask  <= 8'd4;
            r_start <= 1'b0;
        end else begin
            r_start <= 1'b0;
            if (psel && penable && pwrite && paddr[2] == tksd_pkg::REG_CTRL_MASK) begin
                r_mask <= pwdata[7:0];
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (acc_in) begin
                        if (i_item.opcode == tksd_pkg::OP_FLUSH) begin
                            if (r_mode == M_ESC) begin
                                r_mode <= M_NORMAL;
                                r_res1 <= esc_item;
                                r_has2 <= 1'b0; r_state <= ST_OUT1;
                            end
                        end else if (r_mode == M_ESC) begin
                            if (b == 8'h5b) begin
                                r_mode <= M_CSI; r_cnt <= '0;
                            end else begin
                                r_res1 <= esc_item; r_res2 <= pl;
                                r_has2 <= pl_ok && b != 8'h1b;
                                r_mode <= (b == 8'h1b) ? M_ESC : M_NORMAL;
                                r_state <= ST_OUT1;
                            end
                        end else if (r_mode == M_CSI) begin
                            if (b >= 8'h40 && b <= 8'h7e) begin
                                r_fin <= b; r_start <= 1'b1; r_state <= ST_SCAN;
                            end else if (r_cnt < tksd_pkg::CntW'(tksd_pkg::ParamDepth)) begin
                                r_cnt <= r_cnt + 1'b1;
                            end else begin
                                r_mode <= M_NORMAL; r_cnt <= '0;
                            end
                        end else begin
                            if (b == 8'h1b) r_mode <= M_ESC;
                            else if (pl_ok) begin
                                r_res1 <= pl; r_has2 <= 1'b0; r_state <= ST_OUT1;
                            end
                        end
                    end
                end
                ST_SCAN: if (rsp.done) r_state <= ST_FIN;
                ST_FIN: begin
                    r_mode <= M_NORMAL; r_cnt <= '0;
                    r_res1 <= fi; r_has2 <= 1'b0;
                    r_state <= fi_ok ? ST_OUT1 : ST_IDLE;
                end
                ST_OUT1: if (i_ready) r_state <= r_has2 ? ST_OUT2 : ST_IDLE;
                ST_OUT2: if (i_ready) r_state <= ST_IDLE;
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    tksd_ram #(.Width(8), .Depth(tksd_pkg::ParamDepth)) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_cnt[tksd_pkg::PtrW-1:0]),
        .i_wdata (b),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    tksd_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .i_rdata (rdata),
        .o_raddr (raddr),
        .o_rsp   (rsp)
    );
endmodule
